// ===== src/chm_pkg.sv =====
// Shared types, constants and helpers for the cache hit/miss policy model.
package chm_pkg;

  localparam int LinesLog2Default = 10;
  localparam int LineBytesDefault = 32;
  localparam int AddrBitsDefault  = 32;

  localparam int CfgAddrBits = 5;

  typedef enum logic [2:0] {
    REG_SETS_LOG2   = 3'd0,
    REG_WAYS_LOG2   = 3'd1,
    REG_REPLACE_LFU = 3'd2,
    REG_ALLOC_STORE = 3'd3,
    REG_PREFETCH    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PF_NONE   = 2'd0,
    PF_ALWAYS = 2'd1,
    PF_MISS   = 2'd2
  } pf_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_WRITE,
    ST_PF_START,
    ST_PF_SCAN,
    ST_PF_SCAN_LAST,
    ST_PF_WRITE,
    ST_OUT
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch input beat, bump access count
    logic start_demand;
    logic start_pf;
    logic scan;        // issue the read of one way this cycle
    logic write;       // commit lookup result to the arrays
    logic out_load;    // load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_way;
    logic do_pf;
    logic clearing;    // valid bits still being cleared after reset
  } dp_sts_t;

  function automatic int clog2_floor(input int v);
    int s;
    s = 0;
    while (s < 15 && (2 << s) <= v) s++;
    return s;
  endfunction

endpackage

// ===== src/chm_if.sv =====
// Valid/ready channel interface.
interface chm_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/chm_ctl.sv =====
// Controller state machine: sequences lookup passes over the ways.
module chm_ctl
  import chm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == ST_IDLE) && !sts.clearing;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.clearing) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_START;
        end
      end
      ST_START: begin
        cmd.start_demand = 1'b1;
        state_nxt        = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_way) state_nxt = ST_SCAN_LAST;
      end
      // last way's read data is evaluated here
      ST_SCAN_LAST: state_nxt = ST_WRITE;
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_PF_START;
      end
      ST_PF_START: begin
        if (sts.do_pf) begin
          cmd.start_pf = 1'b1;
          state_nxt    = ST_PF_SCAN;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_PF_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_way) state_nxt = ST_PF_SCAN_LAST;
      end
      ST_PF_SCAN_LAST: state_nxt = ST_PF_WRITE;
      ST_PF_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != ST_IDLE) |-> !in_ready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  property p_out_after_load;
    @(posedge clk) disable iff (!rst_n) cmd.out_load |=> out_valid;
  endproperty
  a_out_after_load: assert property (p_out_after_load) else $error("result lost");

  property p_capture_start;
    @(posedge clk) disable iff (!rst_n) cmd.capture |=> state_r == ST_START;
  endproperty
  a_capture_start: assert property (p_capture_start) else $error("bad start");

endmodule

// ===== src/chm_dp.sv =====
// Datapath: tag/rank/valid arrays, serial way walk, counters, config registers.
module chm_dp
  import chm_pkg::*;
#(
  parameter int LINES_LOG2 = LinesLog2Default,
  parameter int LINE_BYTES = LineBytesDefault,
  parameter int ADDR_BITS  = AddrBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic                   in_command,
  input  logic [31:0]            in_address,
  input  logic                   cfg_we,
  input  logic [CfgAddrBits-1:0] cfg_addr,
  input  logic [31:0]            cfg_wdata,
  output logic [31:0]            cfg_rdata,
  output logic                   out_hit,
  output logic                   out_prefetch_filled,
  output logic [31:0]            out_hits_so_far,
  output logic [31:0]            out_accesses_so_far
);

  localparam int Entries = 1 << LINES_LOG2;
  localparam int OffBits = clog2_floor(LINE_BYTES);
  localparam int LineW   = (ADDR_BITS > OffBits) ? ADDR_BITS - OffBits : 1;
  localparam int EW      = LINES_LOG2;
  localparam int CW      = LINES_LOG2 + 1;

  // configuration
  logic [3:0] sets_log2_r, ways_log2_r;
  logic       replace_lfu_r, alloc_r;
  logic [1:0] pf_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sets_log2_r   <= 4'd8;
      ways_log2_r   <= 4'd1;
      replace_lfu_r <= 1'b0;
      alloc_r       <= 1'b1;
      pf_mode_r     <= PF_NONE;
    end else if (cfg_we) begin
      unique case (cfg_addr[CfgAddrBits-1:2])
        REG_SETS_LOG2:   sets_log2_r   <= cfg_wdata[3:0];
        REG_WAYS_LOG2:   ways_log2_r   <= cfg_wdata[3:0];
        REG_REPLACE_LFU: replace_lfu_r <= cfg_wdata[0];
        REG_ALLOC_STORE: alloc_r       <= cfg_wdata[0];
        REG_PREFETCH:    pf_mode_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_addr[CfgAddrBits-1:2])
      REG_SETS_LOG2:   cfg_rdata = {28'd0, sets_log2_r};
      REG_WAYS_LOG2:   cfg_rdata = {28'd0, ways_log2_r};
      REG_REPLACE_LFU: cfg_rdata = {31'd0, replace_lfu_r};
      REG_ALLOC_STORE: cfg_rdata = {31'd0, alloc_r};
      REG_PREFETCH:    cfg_rdata = {30'd0, pf_mode_r};
      default:         cfg_rdata = '0;
    endcase
  end

  // effective geometry
  logic [4:0] s_eff, w_eff, wl_lim;
  always_comb begin
    s_eff  = ({1'b0, sets_log2_r} > 5'(LINES_LOG2)) ? 5'(LINES_LOG2) : {1'b0, sets_log2_r};
    wl_lim = 5'(LINES_LOG2) - s_eff;
    w_eff  = ({1'b0, ways_log2_r} > wl_lim) ? wl_lim : {1'b0, ways_log2_r};
  end

  // per-item registers
  logic             cmd_load_r;
  logic [LineW-1:0] dline_r, line_r;
  logic [31:0]      hit_total_r, access_total_r;
  logic             dhit_r, pfill_r, may_fill_r, is_pf_r;

  // walk state
  logic [CW-1:0]    way_r, rd_way_r;
  logic             rd_valid_r;
  logic [EW-1:0]    base_r;
  logic             found_r, inv_found_r;
  logic [CW-1:0]    found_way_r, inv_way_r, vic_way_r;
  logic [31:0]      vic_rank_r, found_rank_r;

  // arrays: valid bit stored on top of each tag entry
  logic [LineW:0]   tag_mem [Entries];
  logic [31:0]      rank_mem [Entries];
  logic [LineW:0]   q_tag_r;
  logic [31:0]      q_rank_r;

  // clearing pass after reset
  logic             clr_active_r;
  logic [EW-1:0]    clr_idx_r;

  logic [63:0]      addr_ext;
  logic [EW-1:0]    set_of;
  logic [LineW-1:0] start_line;
  logic [EW-1:0]    rd_addr;
  logic [CW-1:0]    nways;
  logic             cur_valid, cur_match, better;
  logic [31:0]      cur_rank;

  assign addr_ext   = {32'd0, in_address};
  assign start_line = cmd.start_pf ? (dline_r + LineW'(1)) : dline_r;
  assign set_of     = EW'(start_line & ((LineW'(1) << s_eff) - LineW'(1)));
  assign nways      = CW'(1) << w_eff;
  assign rd_addr    = base_r + EW'(way_r);
  assign cur_valid  = q_tag_r[LineW];
  assign cur_match  = cur_valid && (q_tag_r[LineW-1:0] == line_r);
  assign cur_rank   = q_rank_r;

  always_comb begin
    if (replace_lfu_r) better = cur_rank < vic_rank_r;
    else better = (access_total_r - cur_rank) > (access_total_r - vic_rank_r);
  end

  assign sts.last_way = (way_r == nways - CW'(1));
  assign sts.do_pf    = (pf_mode_r == PF_ALWAYS) || (pf_mode_r == PF_MISS && !dhit_r);
  assign sts.clearing = clr_active_r;

  logic [EW-1:0] wr_entry;
  logic          wr_fill;
  always_comb begin
    wr_fill  = !found_r && may_fill_r;
    wr_entry = base_r + EW'(found_r ? found_way_r : (inv_found_r ? inv_way_r : vic_way_r));
  end

  // registered read, one way per cycle
  always_ff @(posedge clk) begin
    q_tag_r  <= tag_mem[rd_addr];
    q_rank_r <= rank_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst_n && clr_active_r) begin
      tag_mem[clr_idx_r] <= '0;
    end else if (rst_n && cmd.write) begin
      if (found_r) begin
        if (!replace_lfu_r) rank_mem[wr_entry] <= access_total_r;
        else if (!is_pf_r) rank_mem[wr_entry] <= found_rank_r + 32'd1;
      end else if (wr_fill) begin
        tag_mem[wr_entry]  <= {1'b1, line_r};
        rank_mem[wr_entry] <= replace_lfu_r ? 32'd1 : access_total_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_way_r <= way_r;
    if (cmd.capture) begin
      cmd_load_r <= in_command;
      dline_r    <= LineW'(addr_ext[ADDR_BITS-1:OffBits]);
    end
    if (cmd.start_demand || cmd.start_pf) begin
      line_r      <= start_line;
      base_r      <= EW'(set_of << w_eff);
      way_r       <= '0;
      found_r     <= 1'b0;
      inv_found_r <= 1'b0;
      vic_way_r   <= '0;
      is_pf_r     <= cmd.start_pf;
      may_fill_r  <= cmd.start_pf | cmd_load_r | alloc_r;
    end else begin
      if (cmd.scan) way_r <= way_r + CW'(1);
      // evaluate the way read in the previous cycle
      if (rd_valid_r) begin
        if (cur_match && !found_r) begin
          found_r      <= 1'b1;
          found_way_r  <= rd_way_r;
          found_rank_r <= cur_rank;
        end
        if (!cur_valid && !inv_found_r) begin
          inv_found_r <= 1'b1;
          inv_way_r   <= rd_way_r;
        end
        if (rd_way_r == '0 || (cur_valid && better)) begin
          vic_way_r  <= rd_way_r;
          vic_rank_r <= cur_rank;
        end
      end
    end
    if (cmd.out_load) begin
      out_hit             <= dhit_r;
      out_prefetch_filled <= pfill_r;
      out_hits_so_far     <= hit_total_r;
      out_accesses_so_far <= access_total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r   <= 1'b1;
      clr_idx_r      <= '0;
      rd_valid_r     <= 1'b0;
      hit_total_r    <= '0;
      access_total_r <= '0;
      dhit_r         <= 1'b0;
      pfill_r        <= 1'b0;
    end else begin
      rd_valid_r <= cmd.scan;
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + EW'(1);
        if (&clr_idx_r) clr_active_r <= 1'b0;
      end
      if (cmd.capture) begin
        access_total_r <= access_total_r + 32'd1;
        pfill_r        <= 1'b0;
      end
      if (cmd.write) begin
        if (!is_pf_r) begin
          dhit_r <= found_r;
          if (found_r) hit_total_r <= hit_total_r + 32'd1;
        end else begin
          pfill_r <= wr_fill;
        end
      end
    end
  end

  property p_no_capture_clearing;
    @(posedge clk) disable iff (!rst_n) cmd.capture |-> !clr_active_r;
  endproperty
  a_no_capture_clearing: assert property (p_no_capture_clearing) else $error("beat while clearing");

  property p_hit_count;
    @(posedge clk) disable iff (!rst_n)
      (cmd.write && !is_pf_r && found_r) |=> hit_total_r == $past(hit_total_r) + 32'd1;
  endproperty
  a_hit_count: assert property (p_hit_count) else $error("hit count");

  property p_access_count;
    @(posedge clk) disable iff (!rst_n)
      cmd.capture |=> access_total_r == $past(access_total_r) + 32'd1;
  endproperty
  a_access_count: assert property (p_access_count) else $error("access count");

endmodule

// ===== src/cache_hit_miss_policy_model_top.sv =====
// Cache hit/miss policy model: top level.
// One load or store address enters per input beat on in_ch (valid/ready).
// The block finds its line in a set-associative cache with configurable
// sets, ways, LRU/LFU replacement, store allocation and next-line prefetch,
// and returns one result beat on out_ch: hit, prefetch fill and running
// hit and access counts.
// Ways are read one per cycle from the tag and rank stores with a registered
// read; a lookup pass walks every way of the set and then writes the arrays.
// One item is in flight at a time; the next is taken once the result is
// loaded into the output register, so a waiting result does not block it.
// If the receiver stalls with a result still held, the next result waits
// in the controller until the output register frees.
// Reset sets counters and configuration to defaults, then a clearing pass
// over all 2^LINES_LOG2 entries (1024 by default) zeroes the valid bits
// kept with the tags while in_ready stays low. Configuration is by APB
// writes at 4*index.
module cache_hit_miss_policy_model_top
  import chm_pkg::*;
#(
  parameter int LINES_LOG2 = LinesLog2Default,
  parameter int LINE_BYTES = LineBytesDefault,
  parameter int ADDR_BITS  = AddrBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  chm_if.sink                    in_ch,
  chm_if.source                  out_ch,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CfgAddrBits-1:0] cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;

  chm_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  chm_dp #(
    .LINES_LOG2 (LINES_LOG2),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_command          (in_ch.data[32]),
    .in_address          (in_ch.data[31:0]),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_paddr),
    .cfg_wdata           (cfg_pwdata),
    .cfg_rdata           (cfg_prdata),
    .out_hit             (out_ch.data[65]),
    .out_prefetch_filled (out_ch.data[64]),
    .out_hits_so_far     (out_ch.data[63:32]),
    .out_accesses_so_far (out_ch.data[31:0])
  );

endmodule

// ===== tb/sv/cache_hit_miss_policy_model_top_tb.sv =====
// Testbench for the cache hit/miss policy model: directed table, random phases, predictor.
module cache_hit_miss_policy_model_top_tb;
  import chm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries = 1024;

  typedef struct packed {
    logic        hit;
    logic        pf_filled;
    logic [31:0] hits_so_far;
    logic [31:0] accesses_so_far;
  } cache_result_t;

  typedef struct {
    logic        is_load;
    logic [31:0] addr;
    bit          typed;
    logic        exp_hit;
    logic        exp_pf;
    logic [31:0] exp_hits;
    logic [31:0] exp_acc;
  } access_row_t;

  typedef struct {
    logic [3:0] sets;
    logic [3:0] ways;
    logic       lfu;
    logic       alloc;
    logic [1:0] pf;
    int         count;
  } phase_cfg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CfgAddrBits-1:0] cfg_paddr = '0;
  logic [31:0]            cfg_pwdata = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  chm_if #(.W(33)) in_ch (clk);
  chm_if #(.W(66)) out_ch (clk);

  cache_hit_miss_policy_model_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [3:0]  p_sets, p_ways;
  logic        p_lfu, p_alloc;
  logic [1:0]  p_pf;
  bit          p_valid [Entries];
  logic [26:0] p_tag [Entries];
  logic [31:0] p_rank [Entries];
  logic [31:0] p_hits, p_acc;

  cache_result_t expected_results[$];
  int mismatches = 0;
  int checked = 0;
  int hit_seen = 0;
  int pf_seen = 0;
  int idle_mode = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic bit lookup_line(logic [26:0] line, logic [31:0] now, bit demand,
                                     bit may_fill, ref bit filled);
    int s, wl, nways, base, e, ev, victim;
    s = (p_sets > 10) ? 10 : p_sets;
    wl = (p_ways > 10 - s) ? 10 - s : p_ways;
    nways = 1 << wl;
    base = (int'(line) & ((1 << s) - 1)) << wl;
    for (int w = 0; w < nways; w++) begin
      e = (base + w) & (Entries - 1);
      if (p_valid[e] && p_tag[e] == line) begin
        if (p_lfu) begin
          if (demand) p_rank[e] = p_rank[e] + 32'd1;
        end else begin
          p_rank[e] = now;
        end
        return 1'b1;
      end
    end
    if (!may_fill) return 1'b0;
    victim = nways;
    for (int w = 0; w < nways; w++) begin
      if (!p_valid[(base + w) & (Entries - 1)]) begin
        victim = w;
        break;
      end
    end
    if (victim == nways) begin
      victim = 0;
      for (int w = 1; w < nways; w++) begin
        e = (base + w) & (Entries - 1);
        ev = (base + victim) & (Entries - 1);
        if (p_lfu) begin
          if (p_rank[e] < p_rank[ev]) victim = w;
        end else if (32'(now - p_rank[e]) > 32'(now - p_rank[ev])) begin
          victim = w;
        end
      end
    end
    e = (base + victim) & (Entries - 1);
    p_valid[e] = 1'b1;
    p_tag[e] = line;
    p_rank[e] = p_lfu ? 32'd1 : now;
    filled = 1'b1;
    return 1'b0;
  endfunction

  function automatic cache_result_t predict_access(logic is_load, logic [31:0] addr);
    cache_result_t r;
    logic [26:0] line;
    bit dfill, pfill, hit, dummy;
    line = addr[31:5];
    dfill = 0;
    pfill = 0;
    p_acc = p_acc + 32'd1;
    hit = lookup_line(line, p_acc, 1'b1, is_load || p_alloc, dfill);
    if (hit) p_hits = p_hits + 32'd1;
    if (p_pf == PF_ALWAYS || (p_pf == PF_MISS && !hit))
      dummy = lookup_line(line + 27'd1, p_acc, 1'b0, 1'b1, pfill);
    r.hit = hit;
    r.pf_filled = pfill;
    r.hits_so_far = p_hits;
    r.accesses_so_far = p_acc;
    return r;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CfgAddrBits'(4 * int'(idx));
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_SETS_LOG2:   p_sets = value[3:0];
      REG_WAYS_LOG2:   p_ways = value[3:0];
      REG_REPLACE_LFU: p_lfu = value[0];
      REG_ALLOC_STORE: p_alloc = value[0];
      default:         p_pf = value[1:0];
    endcase
  endtask

  task automatic send_access(access_row_t row);
    cache_result_t r;
    bit accepted;
    int idle_pct;
    idle_pct = (idle_mode == 0) ? 24 : (idle_mode == 1) ? 48 : 0;
    while ($urandom_range(99) < idle_pct) begin
      @(posedge clk);
      in_ch.valid <= 1'b0;
    end
    @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= {row.is_load, row.addr};
    accepted = 0;
    while (!accepted) begin
      @(negedge clk);
      accepted = in_ch.valid && in_ch.ready;
      @(posedge clk);
    end
    in_ch.valid <= 1'b0;
    r = predict_access(row.is_load, row.addr);
    if (row.typed) begin
      r.hit = row.exp_hit;
      r.pf_filled = row.exp_pf;
      r.hits_so_far = row.exp_hits;
      r.accesses_so_far = row.exp_acc;
    end
    expected_results = {expected_results, r};
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    // a result may still be in flight after the last expected one; cover full way walk
    repeat (2200) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    int stall_pct;
    stall_pct = (idle_mode == 0) ? 48 : (idle_mode == 1) ? 24 : 0;
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  bit            out_beat;
  cache_result_t out_sample;
  always @(negedge clk) begin
    out_beat <= out_ch.valid && out_ch.ready && rst_n;
    out_sample <= out_ch.data;
  end

  always @(posedge clk) begin
    cache_result_t e;
    if (out_beat) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_sample);
      end else begin
        e = expected_results.pop_front();
        checked++;
        if (out_sample.hit) hit_seen++;
        if (out_sample.pf_filled) pf_seen++;
        if (out_sample !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%b pf=%b hits=%0d acc=%0d got hit=%b pf=%b hits=%0d acc=%0d",
                     e.hit, e.pf_filled, e.hits_so_far, e.accesses_so_far, out_sample.hit,
                     out_sample.pf_filled, out_sample.hits_so_far, out_sample.accesses_so_far);
        end
      end
    end
  end

  function automatic logic [31:0] pick_address(int region);
    int r;
    r = $urandom_range(99);
    if (r < 70) return {27'(region * 64 + $urandom_range(0, 47)), 5'($urandom_range(0, 31))};
    if (r < 80) return 32'hFFFF_FFFF - 32'($urandom_range(0, 95));
    return $urandom();
  endfunction

  access_row_t directed[] = '{
    '{1'b1, 32'h0000_0000, 1, 1'b0, 1'b0, 32'd0, 32'd1},
    '{1'b1, 32'h0000_001F, 1, 1'b1, 1'b0, 32'd1, 32'd2},
    '{1'b0, 32'hFFFF_FFFF, 1, 1'b0, 1'b0, 32'd1, 32'd3},
    '{1'b0, 32'hFFFF_FFE0, 1, 1'b1, 1'b0, 32'd2, 32'd4},
    '{1'b1, 32'h0000_2000, 0, 0, 0, 0, 0},
    '{1'b1, 32'h0000_4000, 0, 0, 0, 0, 0},
    '{1'b1, 32'h0000_0000, 0, 0, 0, 0, 0},
    '{1'b0, 32'h0000_6000, 0, 0, 0, 0, 0},
    '{1'b1, 32'h0000_2000, 0, 0, 0, 0, 0},
    '{1'b1, 32'hAAAA_AAAA, 0, 0, 0, 0, 0},
    '{1'b0, 32'h5555_5555, 0, 0, 0, 0, 0},
    '{1'b1, 32'h0000_0020, 0, 0, 0, 0, 0}
  };

  phase_cfg_t phases[] = '{
    '{4'd8, 4'd1, 1'b0, 1'b1, 2'd1, 300},
    '{4'd0, 4'd0, 1'b1, 1'b0, 2'd2, 200},
    '{4'd2, 4'd2, 1'b0, 1'b0, 2'd1, 300},
    '{4'd15, 4'd15, 1'b1, 1'b1, 2'd3, 150},
    '{4'd0, 4'd15, 1'b0, 1'b1, 2'd1, 20},
    '{4'd3, 4'd3, 1'b1, 1'b1, 2'd1, 300},
    '{4'd4, 4'd2, 1'b0, 1'b0, 2'd2, 330}
  };

  initial begin
    access_row_t row;
    int total, sent, region;
    p_sets = 4'd8;
    p_ways = 4'd1;
    p_lfu = 1'b0;
    p_alloc = 1'b1;
    p_pf = PF_NONE;
    p_hits = '0;
    p_acc = '0;
    foreach (p_valid[i]) p_valid[i] = 0;
    total = 0;
    foreach (phases[i]) total += phases[i].count;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_access(directed[i]);
    wait_drained();
    sent = 0;
    foreach (phases[p]) begin
      reg_write(REG_SETS_LOG2, 32'(phases[p].sets));
      reg_write(REG_WAYS_LOG2, 32'(phases[p].ways));
      reg_write(REG_REPLACE_LFU, 32'(phases[p].lfu));
      reg_write(REG_ALLOC_STORE, 32'(phases[p].alloc));
      reg_write(REG_PREFETCH, 32'(phases[p].pf));
      region = $urandom_range(0, 1000);
      for (int k = 0; k < phases[p].count; k++) begin
        idle_mode = (sent < total / 3) ? 0 : (sent < 2 * total / 3) ? 1 : 2;
        if (k == phases[p].count / 2 && p == 1) begin
          // hold the sender until the block has returned every result
          while (expected_results.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 49) == 0) region = $urandom_range(0, 1000);
        row.is_load = $urandom_range(0, 2) != 0;
        row.addr = pick_address(region);
        row.typed = 0;
        send_access(row);
        sent++;
      end
      wait_drained();
    end
    $display("Covered %0d results over %0d cache geometries incl. direct mapped and clipped.",
             checked, phases.size() + 1);
    $display("Saw %0d demand hits and %0d prefetch fills under LRU and LFU.", hit_seen, pf_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
